[rtl/tht_pkg.sv]
package tht_pkg;

	localparam int L1_LINES = 256;
	localparam int L2_LINES = 1024;
	localparam int MAX_WAYS = 8;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_L1_OFFSET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_L1_INDEX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_L1_WAYS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_INDEX = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS = 3'd5;

	localparam logic [2:0] ST_NONE = 3'd0;
	localparam logic [2:0] ST_RHIT = 3'd1;
	localparam logic [2:0] ST_RMISS = 3'd2;
	localparam logic [2:0] ST_WHIT = 3'd3;
	localparam logic [2:0] ST_WMISS = 3'd4;

	typedef struct packed {
		logic valid;
		logic [31:0] tag;
		logic [31:0] stamp;
	} line_t;

	typedef struct packed {
		logic [3:0] off_bits;
		logic [3:0] idx_bits;
	} geom_t;

endpackage

[rtl/tht_if.sv]
interface tht_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [31:0] address;
	modport source (output valid, req_type, address, input ready);
	modport sink (input valid, req_type, address, output ready);
endinterface

interface tht_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] l1_status;
	logic [2:0] l2_status;
	modport source (output valid, l1_status, l2_status, input ready);
	modport sink (input valid, l1_status, l2_status, output ready);
endinterface

[rtl/two_level_cache_hit_tracker_unit.sv]
// An access scans the L1 set, one read per way from the L1 memory, then scans the L2 set
// when L2 is consulted, then posts the word.
// One access is in flight at a time; the next one is taken while a finished word waits.
// After reset both tag memories are cleared, one line a cycle, and no access is taken until
// that is done. Configuration resets to 4, 5, 8, 4, 7, 8.
module two_level_cache_hit_tracker_unit #(
	parameter int L1_LINES = tht_pkg::L1_LINES,
	parameter int L2_LINES = tht_pkg::L2_LINES,
	parameter int MAX_WAYS = tht_pkg::MAX_WAYS
) (
	input logic clk,
	input logic arst_n,
	tht_req_if.sink req,
	tht_rsp_if.source rsp,
	input logic cfg_we,
	input logic [tht_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [tht_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tht_pkg::*;

	localparam int WW = $clog2(MAX_WAYS + 1);

	typedef enum logic [2:0] {S_IDLE, S_SCAN1, S_SCAN2, S_OUT} state_t;

	state_t state_q;
	logic [3:0] l1_off_q, l1_idx_q, l1_ways_q, l2_off_q, l2_idx_q, l2_ways_q;
	logic [WW-1:0] l1_ways_eff, l2_ways_eff;
	logic [31:0] count_q;
	logic write_q;
	logic [31:0] addr_q;
	logic [2:0] s1_q, s2_q;
	logic out_v_q;
	logic [2:0] out_s1_q, out_s2_q;
	logic accept;
	logic l1_start, l2_start, l1_upd, l1_fill, l2_upd, l2_fill;
	logic l1_ready, l2_ready, l1_done, l2_done, l1_hit, l2_hit;

	always_comb begin
		l1_ways_eff = WW'(l1_ways_q);
		if (l1_ways_q == 4'd0) begin
			l1_ways_eff = WW'(1);
		end else if (32'(l1_ways_q) > 32'(MAX_WAYS)) begin
			l1_ways_eff = WW'(MAX_WAYS);
		end
		l2_ways_eff = WW'(l2_ways_q);
		if (l2_ways_q == 4'd0) begin
			l2_ways_eff = WW'(1);
		end else if (32'(l2_ways_q) > 32'(MAX_WAYS)) begin
			l2_ways_eff = WW'(MAX_WAYS);
		end
	end

	assign req.ready = state_q == S_IDLE && l1_ready && l2_ready;
	assign accept = req.valid && req.ready;
	assign rsp.valid = out_v_q;
	assign rsp.l1_status = out_s1_q;
	assign rsp.l2_status = out_s2_q;

	always_comb begin
		l1_start = accept;
		l2_start = 1'b0;
		l1_upd = 1'b0;
		l1_fill = 1'b0;
		l2_upd = 1'b0;
		l2_fill = 1'b0;
		if (state_q == S_SCAN1 && l1_done) begin
			if (!write_q && l1_hit) begin
				l1_upd = 1'b1;
			end else begin
				l2_start = 1'b1;
			end
		end
		if (state_q == S_SCAN2 && l2_done) begin
			l1_upd = 1'b1;
			l1_fill = !write_q;
			l2_upd = 1'b1;
			l2_fill = !write_q && !l2_hit;
		end
	end

	tht_level #(.LINES(L1_LINES), .MAX_WAYS(MAX_WAYS)) u_l1 (
		.clk(clk), .arst_n(arst_n), .start(l1_start), .address(req.address),
		.geom('{off_bits: l1_off_q, idx_bits: l1_idx_q}), .ways(l1_ways_eff),
		.upd(l1_upd), .fill(l1_fill), .stamp(count_q),
		.ready(l1_ready), .done(l1_done), .hit(l1_hit)
	);

	tht_level #(.LINES(L2_LINES), .MAX_WAYS(MAX_WAYS)) u_l2 (
		.clk(clk), .arst_n(arst_n), .start(l2_start), .address(addr_q),
		.geom('{off_bits: l2_off_q, idx_bits: l2_idx_q}), .ways(l2_ways_eff),
		.upd(l2_upd), .fill(l2_fill), .stamp(count_q),
		.ready(l2_ready), .done(l2_done), .hit(l2_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			l1_off_q <= 4'd4;
			l1_idx_q <= 4'd5;
			l1_ways_q <= 4'd8;
			l2_off_q <= 4'd4;
			l2_idx_q <= 4'd7;
			l2_ways_q <= 4'd8;
			count_q <= '0;
			out_v_q <= 1'b0;
			out_s1_q <= ST_NONE;
			out_s2_q <= ST_NONE;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_L1_OFFSET: l1_off_q <= cfg_data;
					CFG_L1_INDEX: l1_idx_q <= cfg_data;
					CFG_L1_WAYS: l1_ways_q <= cfg_data;
					CFG_L2_OFFSET: l2_off_q <= cfg_data;
					CFG_L2_INDEX: l2_idx_q <= cfg_data;
					CFG_L2_WAYS: l2_ways_q <= cfg_data;
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= count_q + 32'd1;
						state_q <= S_SCAN1;
					end
				end
				S_SCAN1: begin
					if (l1_done) begin
						if (!write_q && l1_hit) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_SCAN2;
						end
					end
				end
				S_SCAN2: begin
					if (l2_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_v_q || rsp.ready) begin
						out_v_q <= 1'b1;
						out_s1_q <= s1_q;
						out_s2_q <= s2_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			write_q <= req.req_type;
			addr_q <= req.address;
		end
		if (state_q == S_SCAN1 && l1_done) begin
			if (write_q) begin
				s1_q <= l1_hit ? ST_WHIT : ST_WMISS;
			end else begin
				s1_q <= l1_hit ? ST_RHIT : ST_RMISS;
			end
			s2_q <= ST_NONE;
		end
		if (state_q == S_SCAN2 && l2_done) begin
			if (write_q) begin
				s2_q <= l2_hit ? ST_WHIT : ST_WMISS;
			end else begin
				s2_q <= l2_hit ? ST_RHIT : ST_RMISS;
			end
		end
	end

	a_rhit_no_l2: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.l1_status == ST_RHIT |-> rsp.l2_status == ST_NONE)
		else $error("L2 status set on an L1 read hit");

	a_write_pair: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.l1_status == ST_WHIT || rsp.l1_status == ST_WMISS)
		|-> rsp.l2_status == ST_WHIT || rsp.l2_status == ST_WMISS)
		else $error("write word with non-write L2 status");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_SCAN1 && count_q == $past(count_q) + 32'd1)
		else $error("accepted access did not start an L1 scan");

endmodule

[rtl/tht_level.sv]
module tht_level #(
	parameter int LINES = tht_pkg::L1_LINES,
	parameter int MAX_WAYS = tht_pkg::MAX_WAYS,
	localparam int WW = $clog2(MAX_WAYS + 1),
	localparam int AW = (LINES > 1) ? $clog2(LINES) : 1
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] address,
	input tht_pkg::geom_t geom,
	input logic [WW-1:0] ways,
	input logic upd,
	input logic fill,
	input logic [31:0] stamp,
	output logic ready,
	output logic done,
	output logic hit
);
	import tht_pkg::*;

	line_t mem [LINES];
	line_t rd_q;
	logic we;
	logic [AW-1:0] wa;
	line_t wd;

	logic [31:0] addr_q;
	logic [31:0] lt;
	logic [31:0] set_no;
	logic [31:0] ln;
	logic pres;
	logic run_q;
	logic [WW-1:0] way_q;
	logic last;
	logic pend_s1, pres_s1, last_s1;
	logic [AW-1:0] ln_s1;
	logic hit_q, free_q, have_q, done_q;
	logic [31:0] best_q;
	logic [AW-1:0] hit_ln_q, free_ln_q, vic_ln_q;
	logic clearing_q;
	logic [AW-1:0] clr_q;

	assign lt = addr_q >> geom.off_bits;
	assign set_no = lt & ((32'd1 << geom.idx_bits) - 32'd1);
	assign ln = (32'(way_q) << geom.idx_bits) + set_no;
	assign pres = ln < 32'(LINES);
	assign last = way_q == (ways - WW'(1));

	assign ready = !clearing_q;
	assign done = done_q;
	assign hit = hit_q;

	always_comb begin
		if (clearing_q) begin
			we = 1'b1;
			wa = clr_q;
			wd = '0;
		end else begin
			we = upd && (hit_q || (fill && (free_q || have_q)));
			wa = hit_q ? hit_ln_q : (free_q ? free_ln_q : vic_ln_q);
			wd = '{valid: 1'b1, tag: lt, stamp: stamp};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ln[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q <= '0;
			run_q <= 1'b0;
			way_q <= '0;
			pend_s1 <= 1'b0;
			done_q <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			have_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				if (clr_q == AW'(LINES - 1)) begin
					clearing_q <= 1'b0;
				end
				clr_q <= clr_q + AW'(1);
			end
			done_q <= pend_s1 && last_s1;
			if (start) begin
				run_q <= 1'b1;
				way_q <= '0;
				pend_s1 <= 1'b0;
				hit_q <= 1'b0;
				free_q <= 1'b0;
				have_q <= 1'b0;
			end else begin
				pend_s1 <= run_q;
				if (run_q) begin
					if (last) begin
						run_q <= 1'b0;
					end else begin
						way_q <= way_q + WW'(1);
					end
				end
				if (pend_s1 && pres_s1) begin
					if (rd_q.valid && rd_q.tag == lt && !hit_q) begin
						hit_q <= 1'b1;
					end
					if (!rd_q.valid && !free_q) begin
						free_q <= 1'b1;
					end
					if (rd_q.valid && (!have_q || rd_q.stamp < best_q)) begin
						have_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			addr_q <= address;
		end
		pres_s1 <= pres;
		last_s1 <= last;
		ln_s1 <= ln[AW-1:0];
		if (pend_s1 && pres_s1) begin
			if (rd_q.valid && rd_q.tag == lt && !hit_q) begin
				hit_ln_q <= ln_s1;
			end
			if (!rd_q.valid && !free_q) begin
				free_ln_q <= ln_s1;
			end
			if (rd_q.valid && (!have_q || rd_q.stamp < best_q)) begin
				best_q <= rd_q.stamp;
				vic_ln_q <= ln_s1;
			end
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
	import tht_pkg::*;

	typedef struct {
		logic [2:0] l1;
		logic [2:0] l2;
	} status_t;

	typedef struct {
		bit wr;
		logic [31:0] addr;
		bit known;
		logic [2:0] e1;
		logic [2:0] e2;
	} access_row_t;

	localparam int WATCHDOG_CYCLES = 20000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS = 200;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	bit row_known;
	logic [2:0] row_e1, row_e2;

	tht_req_if req_ch();
	tht_rsp_if rsp_ch();

	two_level_cache_hit_tracker_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// Shadow copy of both tag stores; index 0 is L1 and index 1 is L2.
	logic [31:0] shadow_tag[2][L2_LINES];
	logic [31:0] shadow_stamp[2][L2_LINES];
	bit shadow_valid[2][L2_LINES];
	logic [31:0] access_total;
	logic [3:0] geom_reg[6];

	status_t pending_status[$];
	int mismatches;
	int words_checked;
	int read_hits;
	int idle_tx_pct;
	int idle_rx_pct;
	bit start_hold;
	int quiet_cycles;

	access_row_t dir_rows[14];

	function automatic int level_lines(int lvl);
		return lvl ? L2_LINES : L1_LINES;
	endfunction

	function automatic int level_ways(int lvl);
		int w;
		w = lvl ? geom_reg[CFG_L2_WAYS] : geom_reg[CFG_L1_WAYS];
		if (w < 1) w = 1;
		if (w > MAX_WAYS) w = MAX_WAYS;
		return w;
	endfunction

	function automatic logic [31:0] line_tag_of(int lvl, logic [31:0] a);
		return a >> (lvl ? geom_reg[CFG_L2_OFFSET] : geom_reg[CFG_L1_OFFSET]);
	endfunction

	function automatic int line_slot(int lvl, logic [31:0] a, int w);
		longint sets, set_no, ln;
		sets = longint'(1) << (lvl ? geom_reg[CFG_L2_INDEX] : geom_reg[CFG_L1_INDEX]);
		set_no = longint'(line_tag_of(lvl, a)) & (sets - 1);
		ln = w * sets + set_no;
		return (ln < level_lines(lvl)) ? int'(ln) : level_lines(lvl);
	endfunction

	function automatic bit probe_level(int lvl, logic [31:0] a);
		int ln;
		for (int w = 0; w < level_ways(lvl); w++) begin
			ln = line_slot(lvl, a, w);
			if (ln < level_lines(lvl) && shadow_valid[lvl][ln] &&
			    shadow_tag[lvl][ln] == line_tag_of(lvl, a)) begin
				shadow_stamp[lvl][ln] = access_total;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void allocate_line(int lvl, logic [31:0] a);
		int ln;
		int victim;
		bit have;
		logic [31:0] oldest;
		if (probe_level(lvl, a)) return;
		for (int w = 0; w < level_ways(lvl); w++) begin
			ln = line_slot(lvl, a, w);
			if (ln < level_lines(lvl) && !shadow_valid[lvl][ln]) begin
				shadow_valid[lvl][ln] = 1'b1;
				shadow_tag[lvl][ln] = line_tag_of(lvl, a);
				shadow_stamp[lvl][ln] = access_total;
				return;
			end
		end
		have = 1'b0;
		oldest = '0;
		victim = level_lines(lvl);
		for (int w = 0; w < level_ways(lvl); w++) begin
			ln = line_slot(lvl, a, w);
			if (ln < level_lines(lvl) && (!have || shadow_stamp[lvl][ln] < oldest)) begin
				have = 1'b1;
				oldest = shadow_stamp[lvl][ln];
				victim = ln;
			end
		end
		if (victim >= level_lines(lvl)) return;
		shadow_tag[lvl][victim] = line_tag_of(lvl, a);
		shadow_stamp[lvl][victim] = access_total;
	endfunction

	function automatic status_t predict_access(bit wr, logic [31:0] a);
		status_t s;
		access_total = access_total + 32'd1;
		if (!wr) begin
			if (probe_level(0, a)) begin
				s.l1 = ST_RHIT;
				s.l2 = ST_NONE;
			end else if (probe_level(1, a)) begin
				allocate_line(0, a);
				s.l1 = ST_RMISS;
				s.l2 = ST_RHIT;
			end else begin
				allocate_line(0, a);
				allocate_line(1, a);
				s.l1 = ST_RMISS;
				s.l2 = ST_RMISS;
			end
		end else begin
			s.l1 = probe_level(0, a) ? ST_WHIT : ST_WMISS;
			s.l2 = probe_level(1, a) ? ST_WHIT : ST_WMISS;
		end
		return s;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Responses are checked before the request of the same edge is predicted.
	always @(posedge clk) begin
		status_t got, want;
		if (arst_n) begin
			if (cfg_we) geom_reg[cfg_idx] = cfg_data;
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.l1 = rsp_ch.l1_status;
				got.l2 = rsp_ch.l2_status;
				words_checked++;
				if (pending_status.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected word: l1=%0d l2=%0d", got.l1, got.l2);
				end else begin
					want = pending_status.pop_front();
					if (got.l1 !== want.l1 || got.l2 !== want.l2) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected l1=%0d l2=%0d, got l1=%0d l2=%0d",
								want.l1, want.l2, got.l1, got.l2);
					end
					if (want.l1 == ST_RHIT) read_hits++;
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				want = predict_access(req_ch.req_type, req_ch.address);
				if (row_known) begin
					want.l1 = row_e1;
					want.l2 = row_e2;
				end
				pending_status.push_back(want);
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("Timeout after %0d idle cycles", quiet_cycles);
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int hold_left;
		rsp_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (start_hold) begin
				hold_left = 300;
				start_hold = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= idle_rx_pct);
			end
		end
	end

	task automatic send_access(bit wr, logic [31:0] a, bit known, logic [2:0] e1, logic [2:0] e2);
		while ($urandom_range(0, 99) < idle_tx_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= wr;
		req_ch.address <= a;
		row_known <= known;
		row_e1 <= e1;
		row_e2 <= e2;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic drain_all();
		req_ch.valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_geometry(logic [3:0] o1, logic [3:0] x1, logic [3:0] w1,
			logic [3:0] o2, logic [3:0] x2, logic [3:0] w2);
		logic [3:0] vals[6];
		vals = '{o1, x1, w1, o2, x2, w2};
		drain_all();
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [31:0] pool[16];
		logic [31:0] a;
		logic [3:0] g[6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = 1'b0;
		req_ch.address = '0;
		row_known = 1'b0;
		row_e1 = ST_NONE;
		row_e2 = ST_NONE;
		idle_tx_pct = 0;
		idle_rx_pct = 0;
		start_hold = 1'b0;
		quiet_cycles = 0;
		mismatches = 0;
		words_checked = 0;
		read_hits = 0;
		access_total = '0;
		geom_reg = '{4'd4, 4'd5, 4'd8, 4'd4, 4'd7, 4'd8};
		for (int l = 0; l < 2; l++)
			for (int i = 0; i < L2_LINES; i++) begin
				shadow_valid[l][i] = 1'b0;
				shadow_tag[l][i] = '0;
				shadow_stamp[l][i] = '0;
			end

		dir_rows = '{
			'{1'b0, 32'h0000_0000, 1'b1, ST_RMISS, ST_RMISS},
			'{1'b0, 32'h0000_0000, 1'b1, ST_RHIT, ST_NONE},
			'{1'b0, 32'h0000_000F, 1'b1, ST_RHIT, ST_NONE},
			'{1'b1, 32'h0000_0004, 1'b1, ST_WHIT, ST_WHIT},
			'{1'b1, 32'hFFFF_FFFF, 1'b1, ST_WMISS, ST_WMISS},
			'{1'b0, 32'hFFFF_FFFF, 1'b1, ST_RMISS, ST_RMISS},
			'{1'b1, 32'hFFFF_FFF0, 1'b1, ST_WHIT, ST_WHIT},
			'{1'b0, 32'h0000_0200, 1'b0, ST_NONE, ST_NONE},
			'{1'b0, 32'h0000_0400, 1'b0, ST_NONE, ST_NONE},
			'{1'b0, 32'h0000_0600, 1'b0, ST_NONE, ST_NONE},
			'{1'b0, 32'h0000_0800, 1'b0, ST_NONE, ST_NONE},
			'{1'b0, 32'hAAAA_5555, 1'b0, ST_NONE, ST_NONE},
			'{1'b1, 32'h5555_AAAA, 1'b0, ST_NONE, ST_NONE},
			'{1'b0, 32'h0000_0000, 1'b0, ST_NONE, ST_NONE}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset all entries are empty; most rows stress set conflicts on address zero.
		foreach (dir_rows[i])
			send_access(dir_rows[i].wr, dir_rows[i].addr, dir_rows[i].known,
				dir_rows[i].e1, dir_rows[i].e2);
		for (int i = 1; i <= 9; i++)
			send_access(1'b0, 32'(i) << 9, 1'b0, ST_NONE, ST_NONE);
		send_access(1'b0, 32'h0, 1'b0, ST_NONE, ST_NONE);

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: g = '{4'd4, 4'd5, 4'd8, 4'd4, 4'd7, 4'd8};
				1: g = '{4'd0, 4'd0, 4'd1, 4'd0, 4'd0, 4'd1};
				2: g = '{4'd12, 4'd12, 4'd8, 4'd12, 4'd12, 4'd8};
				3: g = '{4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15};
				4: g = '{4'd2, 4'd3, 4'd0, 4'd3, 4'd4, 4'd2};
				5: g = '{4'd6, 4'd0, 4'd4, 4'd6, 4'd2, 4'd3};
				default: for (int k = 0; k < 6; k++) g[k] = 4'($urandom_range(0, 15));
			endcase
			write_geometry(g[0], g[1], g[2], g[3], g[4], g[5]);
			if (ph < 3) begin
				idle_tx_pct = 26;
				idle_rx_pct = 68;
			end else if (ph < 6) begin
				idle_tx_pct = 68;
				idle_rx_pct = 26;
			end else begin
				idle_tx_pct = 0;
				idle_rx_pct = 0;
			end
			if (ph == 0) start_hold = 1'b1;
			for (int k = 0; k < 16; k++) pool[k] = $urandom();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 15)
					a = $urandom();
				else
					a = pool[$urandom_range(0, 15)] ^ 32'($urandom_range(0, 255) << g[0]);
				send_access($urandom_range(0, 99) < 30, a, 1'b0, ST_NONE, ST_NONE);
			end
		end

		drain_all();
		$display("Checked %0d words over 9 cache geometries, %0d of them L1 read hits.",
			words_checked, read_hits);
		$display("Geometries spanned minimum and maximum block, set and way settings.");
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
